FILE: rtl/life_like_automaton_grid_assert.svh
// Assertion macros shared by the grid modules; each expects clk and arst_n in scope.
`ifndef LIFE_LIKE_AUTOMATON_GRID_ASSERT_SVH
`define LIFE_LIKE_AUTOMATON_GRID_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LLA_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grid assertion failed");

// Next-cycle implication, checked outside reset.
`define LLA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid assertion failed");

`endif

FILE: rtl/lla_pkg.sv
// Package with the field widths, codes and interface types of the automaton grid.
`timescale 1ns / 1ps
`default_nettype none

package lla_pkg;

	// Field widths of the item and configuration registers.
	localparam int CMD_W       = 2;
	localparam int COORD_W     = 6;
	localparam int GRID_SIZE_W = 7;
	localparam int MASK_W      = 9;
	localparam int COUNT_W     = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 8;

	// Command codes carried in the input tuser.
	localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_SIZE    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BIRTH_MASK   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SURVIVE_MASK = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST    = 7'd64;
	localparam logic [MASK_W-1:0]      BIRTH_MASK_RST   = 9'd8;
	localparam logic [MASK_W-1:0]      SURVIVE_MASK_RST = 9'd12;

	typedef struct packed {
		logic [GRID_SIZE_W-1:0] grid_size;
		logic [MASK_W-1:0]      birth_mask;
		logic [MASK_W-1:0]      survive_mask;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cell_wr;       // write the addressed cell
		logic cell_rd;       // read the row of the addressed cell
		logic gen_start;     // start a generation: read row 0
		logic gen_first;     // load row 0 into the window, read row 1
		logic gen_row;       // write back one row, shift window, read two rows ahead
		logic res_load;      // load the result register
		logic res_from_read; // result comes from the registered row read
		logic res_oor;       // out-of-range flag for an immediate result
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_range;  // offered row and column lie inside the active square
		logic size_zero; // active square is empty
		logic last_row;  // row being written back is the last active row
	} dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/lla_cfg.sv
// Configuration register file of the automaton grid.
`timescale 1ns / 1ps
`default_nettype none

module lla_cfg import lla_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                        cfg
);

	cfg_t cfg_q;

	// Writes are always taken; an index past the list is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_size    <= GRID_SIZE_RST;
			cfg_q.birth_mask   <= BIRTH_MASK_RST;
			cfg_q.survive_mask <= SURVIVE_MASK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRID_SIZE:    cfg_q.grid_size    <= cfg_data[GRID_SIZE_W-1:0];
				REG_BIRTH_MASK:   cfg_q.birth_mask   <= cfg_data[MASK_W-1:0];
				REG_SURVIVE_MASK: cfg_q.survive_mask <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/lla_ctrl.sv
// Controller state machine of the automaton grid: sequences commands and generations.
`timescale 1ns / 1ps
`default_nettype none
`include "life_like_automaton_grid_assert.svh"

module lla_ctrl import lla_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [CMD_W-1:0] command,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	input  wire dp_status_t       status,
	output dp_cmd_t               cmd
);

	typedef enum logic [3:0] {
		ST_IDLE      = 4'b0001,
		ST_RD_WAIT   = 4'b0010,
		ST_GEN_FIRST = 4'b0100,
		ST_GEN_ROW   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;

	// An item is taken in idle when the result register is free or is being emptied.
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (command)
						CMD_WRITE: begin
							cmd.cell_wr  = status.in_range;
							cmd.res_load = 1'b1;
							cmd.res_oor  = !status.in_range;
						end
						CMD_READ: begin
							if (status.in_range) begin
								cmd.cell_rd = 1'b1;
								state_d     = ST_RD_WAIT;
							end else begin
								cmd.res_load = 1'b1;
								cmd.res_oor  = 1'b1;
							end
						end
						CMD_ADVANCE: begin
							if (status.size_zero) begin
								cmd.res_load = 1'b1;
							end else begin
								cmd.gen_start = 1'b1;
								state_d       = ST_GEN_FIRST;
							end
						end
						default: begin
							cmd.res_load = 1'b1;
						end
					endcase
				end
			end
			ST_RD_WAIT: begin
				cmd.res_load      = 1'b1;
				cmd.res_from_read = 1'b1;
				state_d           = ST_IDLE;
			end
			ST_GEN_FIRST: begin
				cmd.gen_first = 1'b1;
				state_d       = ST_GEN_ROW;
			end
			ST_GEN_ROW: begin
				cmd.gen_row = 1'b1;
				if (status.last_row) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and result-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result is never loaded over one that still waits.
	`LLA_ASSERT_IMPLIES(a_result_slot_free, cmd.res_load, !out_valid_q || m_tready)
	// No result is pending while a generation walks the grid.
	`LLA_ASSERT_IMPLIES(a_no_result_in_walk, state_q == ST_GEN_ROW, !out_valid_q)

endmodule

`default_nettype wire

FILE: rtl/lla_dp.sv
// Datapath of the automaton grid: row memory, row window, cell rule and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "life_like_automaton_grid_assert.svh"

module lla_dp import lla_pkg::*; #(
	parameter int MAX_DIM = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic [COORD_W-1:0] row,
	input  wire logic [COORD_W-1:0] col,
	input  wire logic               alive_value,
	input  wire dp_cmd_t            cmd,
	output dp_status_t              status,
	output logic                    cell_alive,
	output logic                    out_of_range
);

	localparam int AW = $clog2(MAX_DIM);
	localparam int SW = $clog2(MAX_DIM + 1);
	localparam int GW = (SW > GRID_SIZE_W) ? SW : GRID_SIZE_W;
	localparam int KW = (SW > COORD_W) ? SW : COORD_W;
	localparam int RW = SW + 1;

	// Grid rows and one valid bit per row; a row never written reads as dead.
	logic [MAX_DIM-1:0] mem [MAX_DIM];
	logic [MAX_DIM-1:0] row_valid_q;

	logic [SW-1:0]      size_n;
	logic [MAX_DIM-1:0] col_en;
	logic [AW-1:0]      row_q;
	logic [AW-1:0]      col_q;
	logic [RW-1:0]      row_p1;
	logic [RW-1:0]      row_p2;
	logic               next_in;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [MAX_DIM-1:0] wr_data;
	logic [MAX_DIM-1:0] wr_mask;
	logic [MAX_DIM-1:0] col_bit;

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [MAX_DIM-1:0] rd_data_q;
	logic               rd_ok_q;
	logic [MAX_DIM-1:0] rd_row;

	logic [MAX_DIM-1:0] above_q;
	logic [MAX_DIM-1:0] cur_q;
	logic [MAX_DIM-1:0] new_row;
	logic               out_alive_q;
	logic               out_oor_q;

	// Active side length, clipped to the stored grid.
	assign size_n = (GW'(cfg.grid_size) > GW'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(cfg.grid_size);

	always_comb begin
		for (int c = 0; c < MAX_DIM; c++) begin
			col_en[c] = (RW'(c) < RW'(size_n));
		end
	end

	// Row counter arithmetic for the generation walk.
	assign row_p1  = RW'(row_q) + RW'(1);
	assign row_p2  = RW'(row_q) + RW'(2);
	assign next_in = (row_p2 < RW'(size_n));

	assign status.in_range  = (KW'(row) < KW'(size_n)) && (KW'(col) < KW'(size_n));
	assign status.size_zero = (size_n == '0);
	assign status.last_row  = (row_p1 >= RW'(size_n));

	// Write port: a single cell with bit enables, or a whole new row.
	assign col_bit = {{(MAX_DIM-1){1'b0}}, 1'b1} << AW'(col);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		wr_mask = '0;
		if (cmd.cell_wr) begin
			wr_en   = 1'b1;
			wr_addr = AW'(row);
			wr_data = alive_value ? col_bit : '0;
			// A row not yet written is filled whole so its other cells read dead.
			wr_mask = row_valid_q[AW'(row)] ? col_bit : '1;
		end else if (cmd.gen_row) begin
			wr_en   = 1'b1;
			wr_addr = row_q;
			wr_data = new_row;
			wr_mask = '1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < MAX_DIM; i++) begin
				if (wr_mask[i]) begin
					mem[wr_addr][i] <= wr_data[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[wr_addr] <= 1'b1;
		end
	end

	// Read port: rows beyond the active square are not read and count as dead.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (cmd.cell_rd) begin
			rd_en   = 1'b1;
			rd_addr = AW'(row);
		end else if (cmd.gen_start) begin
			rd_en   = 1'b1;
			rd_addr = '0;
		end else if (cmd.gen_first) begin
			rd_en   = (RW'(1) < RW'(size_n));
			rd_addr = AW'(1);
		end else if (cmd.gen_row) begin
			rd_en   = next_in;
			rd_addr = row_p2[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= rd_en && row_valid_q[rd_addr];
		end
	end

	assign rd_row = rd_ok_q ? rd_data_q : '0;

	// Row counter of the generation walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.gen_start) begin
			row_q <= '0;
		end else if (cmd.gen_row) begin
			row_q <= row_p1[AW-1:0];
		end
	end

	// Three-row window: the row above, the row being updated, and the read row below.
	always_ff @(posedge clk) begin
		if (cmd.gen_first) begin
			above_q <= '0;
			cur_q   <= rd_row;
		end else if (cmd.gen_row) begin
			above_q <= cur_q;
			cur_q   <= rd_row;
		end
		if (cmd.cell_rd) begin
			col_q <= AW'(col);
		end
	end

	// Neighbor count and birth or survival of every active cell in the row; other cells keep their value.
	always_comb begin
		logic [MAX_DIM+1:0] ap;
		logic [MAX_DIM+1:0] mp;
		logic [MAX_DIM+1:0] bp;
		logic [COUNT_W-1:0] cnt;
		ap = {1'b0, above_q & col_en, 1'b0};
		mp = {1'b0, cur_q & col_en, 1'b0};
		bp = {1'b0, rd_row & col_en, 1'b0};
		for (int c = 0; c < MAX_DIM; c++) begin
			cnt = COUNT_W'(ap[c]) + COUNT_W'(ap[c+1]) + COUNT_W'(ap[c+2])
				+ COUNT_W'(mp[c]) + COUNT_W'(mp[c+2])
				+ COUNT_W'(bp[c]) + COUNT_W'(bp[c+1]) + COUNT_W'(bp[c+2]);
			if (col_en[c]) begin
				new_row[c] = mp[c+1] ? cfg.survive_mask[cnt] : cfg.birth_mask[cnt];
			end else begin
				new_row[c] = cur_q[c];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			if (cmd.res_from_read) begin
				out_alive_q <= rd_ok_q && rd_data_q[col_q];
				out_oor_q   <= 1'b0;
			end else begin
				out_alive_q <= 1'b0;
				out_oor_q   <= cmd.res_oor;
			end
		end
	end

	assign cell_alive   = out_alive_q;
	assign out_of_range = out_oor_q;

	// A cell write never competes with a row write-back.
	`LLA_ASSERT_IMPLIES(a_single_writer, cmd.cell_wr, !cmd.gen_row)
	// The row walk always follows the window load.
	`LLA_ASSERT_NEXT(a_walk_follows_load, cmd.gen_first, cmd.gen_row)
	// The last row write-back delivers the generation result.
	`LLA_ASSERT_IMPLIES(a_last_row_result, cmd.gen_row && status.last_row, cmd.res_load)

endmodule

`default_nettype wire

FILE: rtl/life_like_automaton_grid.sv
// Life-like automaton grid: stream front end over configuration, controller and datapath.
//
// Usage: items arrive on s_tvalid/s_tready with the command in s_tuser and the cell
// coordinates and write value in s_tdata. Each item gives exactly one result item on
// m_tvalid/m_tready: the read cell state in m_tdata and the out-of-range flag in m_tuser.
// Registers (grid size, birth mask, survive mask) are written over cfg_valid/cfg_ready;
// the user writes them only while the block is idle, which the block does not enforce.
// A write, an out-of-range read or an unused command loads its result on acceptance,
// shown in the cycle after; an in-range read loads it from the registered row memory
// read in a wait state, an advance on its last row (on acceptance for an empty square):
// the walk updates one grid row per cycle through a three-row window, with a row memory
// write each cycle and a read while rows remain. Writes and out-of-range reads sustain
// one item per cycle while m_tready stays high; an in-range read holds off the next item
// until its result loads. While a result waits, a new item is taken only with the result.
// Reset clears the registers to their defaults and all per-row valid bits, so every cell
// reads dead at once without a clearing pass. A stalled receiver holds the result stable
// and the block takes no further item until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module life_like_automaton_grid import lla_pkg::*; #(
	parameter int MAX_DIM = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [S_TDATA_W-1:0]   s_tdata,  // row[5:0], col[11:6], alive_value[12], zero
	input  wire logic [CMD_W-1:0]       s_tuser,  // command[1:0]
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [M_TDATA_W-1:0]        m_tdata,  // cell_alive[0], zero
	output logic                        m_tuser,  // out_of_range[0]
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t               cfg;
	dp_cmd_t            dp_cmd;
	dp_status_t         dp_status;
	logic [COORD_W-1:0] in_row;
	logic [COORD_W-1:0] in_col;
	logic               in_alive;
	logic               res_alive;
	logic               res_oor;

	// Unpack the input item.
	assign in_row   = s_tdata[COORD_W-1:0];
	assign in_col   = s_tdata[2*COORD_W-1:COORD_W];
	assign in_alive = s_tdata[2*COORD_W];

	lla_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.command  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	lla_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.row          (in_row),
		.col          (in_col),
		.alive_value  (in_alive),
		.cmd          (dp_cmd),
		.status       (dp_status),
		.cell_alive   (res_alive),
		.out_of_range (res_oor)
	);

	// Pack the result item.
	assign m_tdata = {{(M_TDATA_W-1){1'b0}}, res_alive};
	assign m_tuser = res_oor;

endmodule

`default_nettype wire
